FILE: src/sgdu_pkg.sv
package sgdu_pkg;

	// Table sizes
	localparam int NUM_USERS  = 4096;
	localparam int NUM_ITEMS  = 4096;
	localparam int LATENT_MAX = 16;
	localparam int TOPK_MAX   = 8;

	localparam int USER_W  = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
	localparam int ITEM_W  = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
	localparam int LAT_W   = (LATENT_MAX > 1) ? $clog2(LATENT_MAX) : 1;
	localparam int TOPK_W  = (TOPK_MAX > 1) ? $clog2(TOPK_MAX) : 1;
	localparam int LATC_W  = $clog2(LATENT_MAX + 1);
	localparam int TOPKC_W = $clog2(TOPK_MAX + 1);
	localparam int UADDR_W = USER_W + LAT_W;
	localparam int IADDR_W = ITEM_W + LAT_W;
	localparam int NADDR_W = USER_W + TOPK_W;

	// Field widths
	localparam int MODE_W   = 3;
	localparam int ID_W     = 12;
	localparam int RATING_W = 15;
	localparam int EL_W     = 4;
	localparam int FACT_W   = 16;
	localparam int CFGI_W   = 3;
	localparam int CFGD_W   = 16;
	localparam int COEF_W   = 16;

	// Datapath widths
	localparam int ACC_W = 32 + LATC_W;
	localparam int S_W   = FACT_W + 1 + TOPKC_W;
	localparam int MA_W  = 34;
	localparam int MB_W  = S_W;
	localparam int P_W   = MA_W + MB_W;
	localparam int K_W   = 33;

	typedef enum logic [MODE_W-1:0] {
		MODE_TRAIN   = 3'd0,
		MODE_WR_USER = 3'd1,
		MODE_WR_ITEM = 3'd2,
		MODE_WR_NBR  = 3'd3,
		MODE_RD_USER = 3'd4,
		MODE_RD_ITEM = 3'd5
	} mode_t;

	typedef enum logic [CFGI_W-1:0] {
		CFG_LATENT  = 3'd0,
		CFG_NBR_CNT = 3'd1,
		CFG_LRATE   = 3'd2,
		CFG_REG     = 3'd3,
		CFG_SOCIAL  = 3'd4
	} cfg_idx_t;

	typedef enum logic [5:0] {
		OP_NONE, OP_CLEAR, OP_ACCEPT, OP_MEMWR, OP_RDREQ, OP_RDCAP,
		OP_PRE_A, OP_PRE_B, OP_PRE_C,
		OP_D_RD, OP_D_MUL, OP_D_ACC,
		OP_E_ERR, OP_E_MUL, OP_E_CAP,
		OP_U_RD, OP_U_M1, OP_U_M2, OP_U_NEWU, OP_U_M3, OP_U_M4, OP_U_NEWI,
		OP_N_RD, OP_N_ST,
		OP_S_RDU, OP_S_ST, OP_S_NRD, OP_S_NACC, OP_S_MUL, OP_S_WR,
		OP_FIN
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [LAT_W-1:0]   k;
		logic [TOPK_W-1:0]  j;
		logic [USER_W-1:0]  clr;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic               ok;
		logic               flag;
		logic [LATC_W-1:0]  dims;
		logic [TOPKC_W-1:0] nbs;
	} stat_t;

	typedef struct packed {
		logic signed [FACT_W-1:0] val;
		logic                     hit;
	} sat_t;

	function automatic sat_t sat16(input logic signed [63:0] v);
		sat_t r;
		if (v > 64'sd32767) begin
			r.val = 16'sh7fff;
			r.hit = 1'b1;
		end else if (v < -64'sd32768) begin
			r.val = 16'sh8000;
			r.hit = 1'b1;
		end else begin
			r.val = v[FACT_W-1:0];
			r.hit = 1'b0;
		end
		return r;
	endfunction

	// Round half up, then floor shift
	function automatic logic signed [63:0] rnd12(input logic signed [63:0] v);
		return (v + 64'sd2048) >>> 12;
	endfunction

	function automatic logic signed [63:0] rnd32(input logic signed [63:0] v);
		return (v + 64'sd2147483648) >>> 32;
	endfunction

endpackage

FILE: src/sgdu_ram.sv
module sgdu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/sgdu_ctrl.sv
module sgdu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  sgdu_pkg::stat_t stat,
	output sgdu_pkg::cmd_t  cmd
);

	localparam int NS = 31;

	typedef enum logic [NS-1:0] {
		ST_CLR   = 31'd1 << 0,
		ST_IDLE  = 31'd1 << 1,
		ST_DEC   = 31'd1 << 2,
		ST_MEMWR = 31'd1 << 3,
		ST_RDREQ = 31'd1 << 4,
		ST_RDCAP = 31'd1 << 5,
		ST_PRE_A = 31'd1 << 6,
		ST_PRE_B = 31'd1 << 7,
		ST_PRE_C = 31'd1 << 8,
		ST_D_RD  = 31'd1 << 9,
		ST_D_MUL = 31'd1 << 10,
		ST_D_ACC = 31'd1 << 11,
		ST_E_ERR = 31'd1 << 12,
		ST_E_MUL = 31'd1 << 13,
		ST_E_CAP = 31'd1 << 14,
		ST_U_RD  = 31'd1 << 15,
		ST_U_M1  = 31'd1 << 16,
		ST_U_M2  = 31'd1 << 17,
		ST_U_NEWU = 31'd1 << 18,
		ST_U_M3  = 31'd1 << 19,
		ST_U_M4  = 31'd1 << 20,
		ST_U_NEWI = 31'd1 << 21,
		ST_N_RD  = 31'd1 << 22,
		ST_N_ST  = 31'd1 << 23,
		ST_S_RDU = 31'd1 << 24,
		ST_S_ST  = 31'd1 << 25,
		ST_S_NRD = 31'd1 << 26,
		ST_S_NACC = 31'd1 << 27,
		ST_S_MUL = 31'd1 << 28,
		ST_S_WR  = 31'd1 << 29,
		ST_FIN   = 31'd1 << 30
	} state_t;

	state_t state_q, state_d;
	logic [sgdu_pkg::LAT_W-1:0]  k_q, k_d;
	logic [sgdu_pkg::TOPK_W-1:0] j_q, j_d;
	logic [sgdu_pkg::USER_W-1:0] clr_q, clr_d;
	logic                        out_valid_q, out_valid_d;
	sgdu_pkg::op_t               op;
	logic k_last, j_last, slot_free;

	assign k_last = (sgdu_pkg::LATC_W'(k_q) + sgdu_pkg::LATC_W'(1)) == stat.dims;
	assign j_last = (sgdu_pkg::TOPKC_W'(j_q) + sgdu_pkg::TOPKC_W'(1)) == stat.nbs;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		j_d     = j_q;
		clr_d   = clr_q;
		op      = sgdu_pkg::OP_NONE;
		unique case (state_q)
			ST_CLR: begin
				op    = sgdu_pkg::OP_CLEAR;
				clr_d = clr_q + 1'b1;
				if (32'(clr_q) == sgdu_pkg::NUM_USERS - 1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					op      = sgdu_pkg::OP_ACCEPT;
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				k_d = '0;
				j_d = '0;
				if (!stat.ok) begin
					state_d = ST_FIN;
				end else if (stat.mode == sgdu_pkg::MODE_TRAIN) begin
					state_d = ST_PRE_A;
				end else if (stat.mode == sgdu_pkg::MODE_RD_USER ||
				             stat.mode == sgdu_pkg::MODE_RD_ITEM) begin
					state_d = ST_RDREQ;
				end else begin
					state_d = ST_MEMWR;
				end
			end
			ST_MEMWR: begin
				op      = sgdu_pkg::OP_MEMWR;
				state_d = ST_FIN;
			end
			ST_RDREQ: begin
				op      = sgdu_pkg::OP_RDREQ;
				state_d = ST_RDCAP;
			end
			ST_RDCAP: begin
				op      = sgdu_pkg::OP_RDCAP;
				state_d = ST_FIN;
			end
			ST_PRE_A: begin
				op      = sgdu_pkg::OP_PRE_A;
				state_d = ST_PRE_B;
			end
			ST_PRE_B: begin
				op      = sgdu_pkg::OP_PRE_B;
				state_d = ST_PRE_C;
			end
			ST_PRE_C: begin
				op      = sgdu_pkg::OP_PRE_C;
				state_d = (stat.dims == '0) ? ST_E_ERR : ST_D_RD;
			end
			ST_D_RD: begin
				op      = sgdu_pkg::OP_D_RD;
				state_d = ST_D_MUL;
			end
			ST_D_MUL: begin
				op      = sgdu_pkg::OP_D_MUL;
				state_d = ST_D_ACC;
			end
			ST_D_ACC: begin
				op = sgdu_pkg::OP_D_ACC;
				if (k_last) begin
					k_d     = '0;
					state_d = ST_E_ERR;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = ST_D_RD;
				end
			end
			ST_E_ERR: begin
				op      = sgdu_pkg::OP_E_ERR;
				state_d = ST_E_MUL;
			end
			ST_E_MUL: begin
				op      = sgdu_pkg::OP_E_MUL;
				state_d = ST_E_CAP;
			end
			ST_E_CAP: begin
				op      = sgdu_pkg::OP_E_CAP;
				state_d = (stat.dims == '0) ? ST_FIN : ST_U_RD;
			end
			ST_U_RD: begin
				op      = sgdu_pkg::OP_U_RD;
				state_d = ST_U_M1;
			end
			ST_U_M1: begin
				op      = sgdu_pkg::OP_U_M1;
				state_d = ST_U_M2;
			end
			ST_U_M2: begin
				op      = sgdu_pkg::OP_U_M2;
				state_d = ST_U_NEWU;
			end
			ST_U_NEWU: begin
				op      = sgdu_pkg::OP_U_NEWU;
				state_d = ST_U_M3;
			end
			ST_U_M3: begin
				op      = sgdu_pkg::OP_U_M3;
				state_d = ST_U_M4;
			end
			ST_U_M4: begin
				op      = sgdu_pkg::OP_U_M4;
				state_d = ST_U_NEWI;
			end
			ST_U_NEWI: begin
				op = sgdu_pkg::OP_U_NEWI;
				if (k_last) begin
					k_d     = '0;
					j_d     = '0;
					state_d = (stat.flag && stat.nbs != '0) ? ST_N_RD : ST_FIN;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = ST_U_RD;
				end
			end
			ST_N_RD: begin
				op      = sgdu_pkg::OP_N_RD;
				state_d = ST_N_ST;
			end
			ST_N_ST: begin
				op = sgdu_pkg::OP_N_ST;
				if (j_last) begin
					j_d     = '0;
					state_d = ST_S_RDU;
				end else begin
					j_d     = j_q + 1'b1;
					state_d = ST_N_RD;
				end
			end
			ST_S_RDU: begin
				op      = sgdu_pkg::OP_S_RDU;
				state_d = ST_S_ST;
			end
			ST_S_ST: begin
				op      = sgdu_pkg::OP_S_ST;
				state_d = ST_S_NRD;
			end
			ST_S_NRD: begin
				op      = sgdu_pkg::OP_S_NRD;
				state_d = ST_S_NACC;
			end
			ST_S_NACC: begin
				op = sgdu_pkg::OP_S_NACC;
				if (j_last) begin
					j_d     = '0;
					state_d = ST_S_MUL;
				end else begin
					j_d     = j_q + 1'b1;
					state_d = ST_S_NRD;
				end
			end
			ST_S_MUL: begin
				op      = sgdu_pkg::OP_S_MUL;
				state_d = ST_S_WR;
			end
			ST_S_WR: begin
				op = sgdu_pkg::OP_S_WR;
				if (k_last) begin
					state_d = ST_FIN;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = ST_S_RDU;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					op      = sgdu_pkg::OP_FIN;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (op == sgdu_pkg::OP_FIN) out_valid_d = 1'b1;
		else if (out_ready)         out_valid_d = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			k_q         <= '0;
			j_q         <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			k_q         <= k_d;
			j_q         <= j_d;
			clr_q       <= clr_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign cmd.op    = op;
	assign cmd.k     = k_q;
	assign cmd.j     = j_q;
	assign cmd.clr   = clr_q;

endmodule

FILE: src/sgdu_dp.sv
module sgdu_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sgdu_pkg::cmd_t                      cmd,
	output sgdu_pkg::stat_t                     stat,
	input  logic                                cfg_valid,
	input  logic [sgdu_pkg::CFGI_W-1:0]         cfg_index,
	input  logic [sgdu_pkg::CFGD_W-1:0]         cfg_data,
	input  logic [sgdu_pkg::MODE_W-1:0]         mode,
	input  logic [sgdu_pkg::ID_W-1:0]           user_id,
	input  logic [sgdu_pkg::ID_W-1:0]           item_id,
	input  logic [sgdu_pkg::RATING_W-1:0]       rating,
	input  logic [sgdu_pkg::EL_W-1:0]           element_index,
	input  logic signed [sgdu_pkg::FACT_W-1:0]  factor_value,
	input  logic [sgdu_pkg::ID_W-1:0]           neighbor_id,
	output logic signed [sgdu_pkg::FACT_W-1:0]  read_value,
	output logic signed [sgdu_pkg::FACT_W-1:0]  prediction_error,
	output logic                                saturated
);

	localparam int FW = sgdu_pkg::FACT_W;

	// Configuration
	logic [4:0]                  latent_q;
	logic [3:0]                  nbr_cnt_q;
	logic [sgdu_pkg::COEF_W-1:0] lrate_q, reg_q, soc_q;

	// Latched item
	logic [sgdu_pkg::MODE_W-1:0]   mode_q;
	logic [sgdu_pkg::ID_W-1:0]     uid_q, iid_q, nid_q;
	logic [sgdu_pkg::RATING_W-1:0] rating_q;
	logic [sgdu_pkg::EL_W-1:0]     el_q;
	logic signed [FW-1:0]          fval_q;

	// Working registers
	logic signed [sgdu_pkg::ACC_W-1:0] acc_q;
	logic signed [FW-1:0]              err_q, rv_q, uo_q, io_q, unew_q, uk_q;
	logic                              sat_q;
	logic signed [sgdu_pkg::K_W-1:0]   lr_reg_q, w_q, lr_err_q;
	logic signed [sgdu_pkg::P_W-1:0]   prod_q, t1_q;
	logic signed [sgdu_pkg::S_W-1:0]   s_q;
	logic [sgdu_pkg::ID_W-1:0]         nb_q [sgdu_pkg::TOPK_MAX];

	// Output register
	logic signed [FW-1:0] read_value_q, perr_q;
	logic                 saturated_q;

	logic signed [sgdu_pkg::MA_W-1:0] mul_a;
	logic signed [sgdu_pkg::MB_W-1:0] mul_b;
	sgdu_pkg::sat_t err_s, upd_s, soc_s;
	logic signed [63:0] upd_x;
	logic signed [FW-1:0] upd_src;

	// Memory ports
	logic                         u_we, i_we, n_we, f_we;
	logic [sgdu_pkg::UADDR_W-1:0] u_waddr, u_raddr;
	logic [sgdu_pkg::IADDR_W-1:0] i_waddr, i_raddr;
	logic [sgdu_pkg::NADDR_W-1:0] n_waddr, n_raddr;
	logic [sgdu_pkg::USER_W-1:0]  f_waddr;
	logic [FW-1:0]                u_wdata, i_wdata, u_rdata, i_rdata;
	logic [sgdu_pkg::ID_W-1:0]    n_rdata;
	logic                         f_wdata, f_rdata;
	logic signed [FW-1:0]         urd, ird;
	logic [sgdu_pkg::ID_W-1:0]    nb_sel;
	logic                         uid_ok, iid_ok, el_ok, slot_ok, nb_ok;
	logic [sgdu_pkg::LAT_W-1:0]   el_lat;
	logic [sgdu_pkg::TOPK_W-1:0]  el_slot;

	assign urd     = $signed(u_rdata);
	assign ird     = $signed(i_rdata);
	assign nb_sel  = nb_q[cmd.j];
	assign el_lat  = sgdu_pkg::LAT_W'(el_q);
	assign el_slot = sgdu_pkg::TOPK_W'(el_q);
	assign uid_ok  = 32'(uid_q) < sgdu_pkg::NUM_USERS;
	assign iid_ok  = 32'(iid_q) < sgdu_pkg::NUM_ITEMS;
	assign el_ok   = 32'(el_q) < sgdu_pkg::LATENT_MAX;
	assign slot_ok = 32'(el_q) < sgdu_pkg::TOPK_MAX;
	assign nb_ok   = 32'(nb_sel) < sgdu_pkg::NUM_USERS;

	function automatic logic [sgdu_pkg::UADDR_W-1:0] uaddr(
		input logic [sgdu_pkg::ID_W-1:0]  id,
		input logic [sgdu_pkg::LAT_W-1:0] k
	);
		return {sgdu_pkg::USER_W'(id), k};
	endfunction

	function automatic logic [sgdu_pkg::IADDR_W-1:0] iaddr(
		input logic [sgdu_pkg::ID_W-1:0]  id,
		input logic [sgdu_pkg::LAT_W-1:0] k
	);
		return {sgdu_pkg::ITEM_W'(id), k};
	endfunction

	// Status
	always_comb begin
		stat.mode = mode_q;
		stat.flag = f_rdata;
		stat.dims = (32'(latent_q) > sgdu_pkg::LATENT_MAX) ?
			sgdu_pkg::LATC_W'(sgdu_pkg::LATENT_MAX) : sgdu_pkg::LATC_W'(latent_q);
		stat.nbs  = (32'(nbr_cnt_q) > sgdu_pkg::TOPK_MAX) ?
			sgdu_pkg::TOPKC_W'(sgdu_pkg::TOPK_MAX) : sgdu_pkg::TOPKC_W'(nbr_cnt_q);
		if (mode_q == sgdu_pkg::MODE_TRAIN) stat.ok = uid_ok && iid_ok;
		else if (mode_q == sgdu_pkg::MODE_WR_USER || mode_q == sgdu_pkg::MODE_RD_USER)
			stat.ok = uid_ok && el_ok;
		else if (mode_q == sgdu_pkg::MODE_WR_ITEM || mode_q == sgdu_pkg::MODE_RD_ITEM)
			stat.ok = iid_ok && el_ok;
		else if (mode_q == sgdu_pkg::MODE_WR_NBR) stat.ok = uid_ok && slot_ok;
		else stat.ok = 1'b0;
	end

	// Shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			sgdu_pkg::OP_PRE_A: begin
				mul_a = $signed(sgdu_pkg::MA_W'(lrate_q));
				mul_b = $signed(sgdu_pkg::MB_W'(reg_q));
			end
			sgdu_pkg::OP_PRE_B: begin
				mul_a = $signed(sgdu_pkg::MA_W'(lrate_q));
				mul_b = $signed(sgdu_pkg::MB_W'(soc_q));
			end
			sgdu_pkg::OP_D_MUL: begin
				mul_a = sgdu_pkg::MA_W'(urd);
				mul_b = sgdu_pkg::MB_W'(ird);
			end
			sgdu_pkg::OP_E_MUL: begin
				mul_a = $signed(sgdu_pkg::MA_W'(lrate_q));
				mul_b = sgdu_pkg::MB_W'(err_q);
			end
			sgdu_pkg::OP_U_M1: begin
				mul_a = sgdu_pkg::MA_W'(lr_err_q);
				mul_b = sgdu_pkg::MB_W'(ird);
			end
			sgdu_pkg::OP_U_M2: begin
				mul_a = sgdu_pkg::MA_W'(lr_reg_q);
				mul_b = sgdu_pkg::MB_W'(uo_q);
			end
			sgdu_pkg::OP_U_M3: begin
				mul_a = sgdu_pkg::MA_W'(lr_err_q);
				mul_b = sgdu_pkg::MB_W'(unew_q);
			end
			sgdu_pkg::OP_U_M4: begin
				mul_a = sgdu_pkg::MA_W'(lr_reg_q);
				mul_b = sgdu_pkg::MB_W'(io_q);
			end
			sgdu_pkg::OP_S_MUL: begin
				mul_a = sgdu_pkg::MA_W'(w_q);
				mul_b = sgdu_pkg::MB_W'(s_q);
			end
			default: ;
		endcase
	end

	// Error, factor step and social step
	always_comb begin
		err_s   = sgdu_pkg::sat16(sgdu_pkg::rnd12(
			$signed(64'({rating_q, 12'b0})) - 64'(acc_q)));
		upd_x   = 64'(prod_q) - (64'(t1_q) <<< 4);
		upd_src = (cmd.op == sgdu_pkg::OP_U_NEWI) ? io_q : uo_q;
		upd_s   = sgdu_pkg::sat16(64'(upd_src) - sgdu_pkg::rnd32(upd_x));
		soc_s   = sgdu_pkg::sat16(64'(uk_q) - sgdu_pkg::rnd32(64'(prod_q)));
	end

	// Memory addressing
	always_comb begin
		u_raddr = uaddr(uid_q, cmd.k);
		if (cmd.op == sgdu_pkg::OP_S_NRD) u_raddr = uaddr(nb_sel, cmd.k);
		else if (cmd.op == sgdu_pkg::OP_RDREQ) u_raddr = uaddr(uid_q, el_lat);
		i_raddr = (cmd.op == sgdu_pkg::OP_RDREQ) ? iaddr(iid_q, el_lat) : iaddr(iid_q, cmd.k);
		n_raddr = {sgdu_pkg::USER_W'(uid_q), cmd.j};

		u_we    = 1'b0;
		u_waddr = uaddr(uid_q, cmd.k);
		u_wdata = upd_s.val;
		i_we    = 1'b0;
		i_waddr = iaddr(iid_q, cmd.k);
		i_wdata = upd_s.val;
		n_we    = 1'b0;
		n_waddr = {sgdu_pkg::USER_W'(uid_q), el_slot};
		f_we    = 1'b0;
		f_waddr = sgdu_pkg::USER_W'(uid_q);
		f_wdata = 1'b1;
		unique case (cmd.op)
			sgdu_pkg::OP_CLEAR: begin
				f_we    = 1'b1;
				f_waddr = cmd.clr;
				f_wdata = 1'b0;
			end
			sgdu_pkg::OP_U_NEWU: u_we = 1'b1;
			sgdu_pkg::OP_U_NEWI: i_we = 1'b1;
			sgdu_pkg::OP_S_WR: begin
				u_we    = 1'b1;
				u_wdata = soc_s.val;
			end
			sgdu_pkg::OP_MEMWR: begin
				u_waddr = uaddr(uid_q, el_lat);
				u_wdata = fval_q;
				i_waddr = iaddr(iid_q, el_lat);
				i_wdata = fval_q;
				u_we    = (mode_q == sgdu_pkg::MODE_WR_USER);
				i_we    = (mode_q == sgdu_pkg::MODE_WR_ITEM);
				n_we    = (mode_q == sgdu_pkg::MODE_WR_NBR);
				f_we    = (mode_q == sgdu_pkg::MODE_WR_NBR);
			end
			default: ;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latent_q  <= 5'd10;
			nbr_cnt_q <= 4'd5;
			lrate_q   <= 16'd655;
			reg_q     <= 16'd655;
			soc_q     <= 16'd655;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sgdu_pkg::CFG_LATENT:  latent_q  <= cfg_data[4:0];
				sgdu_pkg::CFG_NBR_CNT: nbr_cnt_q <= cfg_data[3:0];
				sgdu_pkg::CFG_LRATE:   lrate_q   <= cfg_data;
				sgdu_pkg::CFG_REG:     reg_q     <= cfg_data;
				sgdu_pkg::CFG_SOCIAL:  soc_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (cmd.op)
			sgdu_pkg::OP_ACCEPT: begin
				mode_q   <= mode;
				uid_q    <= user_id;
				iid_q    <= item_id;
				rating_q <= rating;
				el_q     <= element_index;
				fval_q   <= factor_value;
				nid_q    <= neighbor_id;
				acc_q    <= '0;
				err_q    <= '0;
				rv_q     <= '0;
				sat_q    <= 1'b0;
			end
			sgdu_pkg::OP_RDCAP:
				rv_q <= (mode_q == sgdu_pkg::MODE_RD_USER) ? urd : ird;
			sgdu_pkg::OP_PRE_B: lr_reg_q <= prod_q[sgdu_pkg::K_W-1:0];
			sgdu_pkg::OP_PRE_C: w_q      <= prod_q[sgdu_pkg::K_W-1:0];
			sgdu_pkg::OP_D_ACC: acc_q    <= acc_q + sgdu_pkg::ACC_W'(prod_q);
			sgdu_pkg::OP_E_ERR: begin
				err_q <= err_s.val;
				sat_q <= sat_q | err_s.hit;
			end
			sgdu_pkg::OP_E_CAP: lr_err_q <= prod_q[sgdu_pkg::K_W-1:0];
			sgdu_pkg::OP_U_M1: begin
				uo_q <= urd;
				io_q <= ird;
			end
			sgdu_pkg::OP_U_M2, sgdu_pkg::OP_U_M4: t1_q <= prod_q;
			sgdu_pkg::OP_U_NEWU: begin
				unew_q <= upd_s.val;
				sat_q  <= sat_q | upd_s.hit;
			end
			sgdu_pkg::OP_U_NEWI: sat_q <= sat_q | upd_s.hit;
			sgdu_pkg::OP_N_ST:   nb_q[cmd.j] <= n_rdata;
			sgdu_pkg::OP_S_ST: begin
				uk_q <= urd;
				s_q  <= '0;
			end
			sgdu_pkg::OP_S_NACC:
				if (nb_ok) s_q <= s_q + sgdu_pkg::S_W'(uk_q) - sgdu_pkg::S_W'(urd);
			sgdu_pkg::OP_S_WR: sat_q <= sat_q | soc_s.hit;
			sgdu_pkg::OP_FIN: begin
				read_value_q <= rv_q;
				perr_q       <= err_q;
				saturated_q  <= sat_q;
			end
			default: ;
		endcase
	end

	sgdu_ram #(.WIDTH(FW), .DEPTH(sgdu_pkg::NUM_USERS * sgdu_pkg::LATENT_MAX)) u_user_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr),
		.wdata (u_wdata),
		.raddr (u_raddr),
		.rdata (u_rdata)
	);

	sgdu_ram #(.WIDTH(FW), .DEPTH(sgdu_pkg::NUM_ITEMS * sgdu_pkg::LATENT_MAX)) u_item_ram (
		.clk   (clk),
		.we    (i_we),
		.waddr (i_waddr),
		.wdata (i_wdata),
		.raddr (i_raddr),
		.rdata (i_rdata)
	);

	sgdu_ram #(.WIDTH(sgdu_pkg::ID_W), .DEPTH(sgdu_pkg::NUM_USERS * sgdu_pkg::TOPK_MAX))
	u_nbr_ram (
		.clk   (clk),
		.we    (n_we),
		.waddr (n_waddr),
		.wdata (nid_q),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	sgdu_ram #(.WIDTH(1), .DEPTH(sgdu_pkg::NUM_USERS)) u_flag_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr),
		.wdata (f_wdata),
		.raddr (sgdu_pkg::USER_W'(uid_q)),
		.rdata (f_rdata)
	);

	assign read_value       = read_value_q;
	assign prediction_error = perr_q;
	assign saturated        = saturated_q;

endmodule

FILE: src/social_mf_sgd_update_unit.sv
// Channel   Handshake               Beat contents
// in        in_valid / in_ready     mode, user_id, item_id, rating, element_index,
//                                   factor_value, neighbor_id
// out       out_valid / out_ready   read_value, prediction_error, saturated
// cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item at a time; a finished result sits in the output register so the
// next beat is taken while it waits. Training runs a dot product, the factor
// updates and, when the user has neighbors, a social pass, all through one
// shared multiplier and the single read port of the user factor memory.
// After reset a clearing pass over every user zeros the social flags; no input
// beat is taken until it ends. Config writes are taken at any time.
module social_mf_sgd_update_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [sgdu_pkg::MODE_W-1:0]         mode,
	input  logic [sgdu_pkg::ID_W-1:0]           user_id,
	input  logic [sgdu_pkg::ID_W-1:0]           item_id,
	input  logic [sgdu_pkg::RATING_W-1:0]       rating,
	input  logic [sgdu_pkg::EL_W-1:0]           element_index,
	input  logic signed [sgdu_pkg::FACT_W-1:0]  factor_value,
	input  logic [sgdu_pkg::ID_W-1:0]           neighbor_id,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [sgdu_pkg::FACT_W-1:0]  read_value,
	output logic signed [sgdu_pkg::FACT_W-1:0]  prediction_error,
	output logic                                saturated,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sgdu_pkg::CFGI_W-1:0]         cfg_index,
	input  logic [sgdu_pkg::CFGD_W-1:0]         cfg_data
);

	sgdu_pkg::cmd_t  cmd;
	sgdu_pkg::stat_t stat;

	// Config registers accept a beat every cycle
	assign cfg_ready = 1'b1;

	// Sequencer: clearing pass, decode, table writes and reads, dot product, updates, social pass
	sgdu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Factor tables, multiplier and output register
	sgdu_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mode             (mode),
		.user_id          (user_id),
		.item_id          (item_id),
		.rating           (rating),
		.element_index    (element_index),
		.factor_value     (factor_value),
		.neighbor_id      (neighbor_id),
		.read_value       (read_value),
		.prediction_error (prediction_error),
		.saturated        (saturated)
	);

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
	import sgdu_pkg::*;

	// Codes with no member in the package mode enum
	localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd6;
	localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd7;
	localparam int N_PHASES = 6;
	localparam int PHASE_ITEMS = 159;

	typedef struct {
		logic [MODE_W-1:0]         mode;
		logic [ID_W-1:0]           uid;
		logic [ID_W-1:0]           iid;
		logic [RATING_W-1:0]       rating;
		logic [EL_W-1:0]           el;
		logic signed [FACT_W-1:0]  fv;
		logic [ID_W-1:0]           nid;
	} sgd_item_t;

	typedef struct {
		logic signed [FACT_W-1:0] rv;
		logic signed [FACT_W-1:0] pe;
		logic                     sat;
	} sgd_res_t;

	// Directed row: item, then a typed result used when chk is set
	typedef struct {
		logic [MODE_W-1:0]         mode;
		logic [ID_W-1:0]           uid;
		logic [ID_W-1:0]           iid;
		logic [RATING_W-1:0]       rating;
		logic [EL_W-1:0]           el;
		logic signed [FACT_W-1:0]  fv;
		logic [ID_W-1:0]           nid;
		bit                        chk;
		logic signed [FACT_W-1:0]  rv;
		logic signed [FACT_W-1:0]  pe;
		logic                      sat;
	} dir_row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	logic [MODE_W-1:0] mode;
	logic [ID_W-1:0] user_id, item_id, neighbor_id;
	logic [RATING_W-1:0] rating;
	logic [EL_W-1:0] element_index;
	logic signed [FACT_W-1:0] factor_value, read_value, prediction_error;
	logic saturated;
	logic [CFGI_W-1:0] cfg_index;
	logic [CFGD_W-1:0] cfg_data;

	social_mf_sgd_update_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .user_id(user_id), .item_id(item_id), .rating(rating),
		.element_index(element_index), .factor_value(factor_value),
		.neighbor_id(neighbor_id),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_value(read_value), .prediction_error(prediction_error),
		.saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow tables and registers of the block
	logic signed [FACT_W-1:0] user_tab [NUM_USERS*LATENT_MAX];
	logic signed [FACT_W-1:0] item_tab [NUM_ITEMS*LATENT_MAX];
	logic [ID_W-1:0] nbr_tab [NUM_USERS*TOPK_MAX];
	bit social_on [NUM_USERS];
	longint dim_reg, nbr_reg, lrate_reg, lambda_reg, social_reg;
	bit clip_hit;

	sgd_res_t pending_res [$];
	int mismatches;
	bit calm;
	int hold_cycles;

	// Only these ids are ever read back or trained on, and all their entries
	// are loaded first; the first five carry neighbor lists
	int unsigned user_pool [9] = '{0, 1, 2, 3, 4095, 4, 5, 6, 7};
	int unsigned item_pool [9] = '{0, 1, 2, 3, 4, 5, 6, 7, 4095};

	dir_row_t dir_rows [18] = '{
		'{MODE_WR_USER, 12'd4095, 12'd0, 15'd0, 4'd15, 16'sh7fff, 12'd0, 1, 16'sd0, 16'sd0, 1'b0},
		'{MODE_RD_USER, 12'd4095, 12'd0, 15'd0, 4'd15, 16'sd0, 12'd0, 1, 16'sh7fff, 16'sd0, 1'b0},
		'{MODE_WR_ITEM, 12'd0, 12'd0, 15'd0, 4'd0, 16'sh8000, 12'd0, 1, 16'sd0, 16'sd0, 1'b0},
		'{MODE_RD_ITEM, 12'd0, 12'd0, 15'd0, 4'd0, 16'sd0, 12'd0, 1, 16'sh8000, 16'sd0, 1'b0},
		'{MODE_WR_ITEM, 12'd0, 12'd4095, 15'd0, 4'd15, 16'sd0, 12'd0, 1, 16'sd0, 16'sd0, 1'b0},
		'{MODE_RD_ITEM, 12'd0, 12'd4095, 15'd0, 4'd15, 16'sd0, 12'd0, 1, 16'sd0, 16'sd0, 1'b0},
		'{MODE_SPARE_A, 12'd4095, 12'd4095, 15'h7fff, 4'd15, 16'shffff, 12'd4095, 1,
			16'sd0, 16'sd0, 1'b0},
		'{MODE_SPARE_B, 12'd0, 12'd0, 15'd0, 4'd0, 16'sd0, 12'd0, 1, 16'sd0, 16'sd0, 1'b0},
		'{MODE_WR_NBR, 12'd5, 12'd0, 15'd0, 4'd8, 16'sd0, 12'd4095, 1, 16'sd0, 16'sd0, 1'b0},
		'{MODE_WR_NBR, 12'd0, 12'd0, 15'd0, 4'd7, 16'sd0, 12'd4095, 1, 16'sd0, 16'sd0, 1'b0},
		'{MODE_TRAIN, 12'd0, 12'd0, 15'h7fff, 4'd0, 16'sd0, 12'd0, 0, 16'sd0, 16'sd0, 1'b0},
		'{MODE_TRAIN, 12'd4095, 12'd4095, 15'd0, 4'd0, 16'sd0, 12'd0, 0, 16'sd0, 16'sd0, 1'b0},
		'{MODE_TRAIN, 12'd5, 12'd1, 15'd16384, 4'd0, 16'sd0, 12'd0, 0, 16'sd0, 16'sd0, 1'b0},
		'{MODE_TRAIN, 12'd4095, 12'd0, 15'h7fff, 4'd0, 16'sd0, 12'd0, 0, 16'sd0, 16'sd0, 1'b0},
		'{MODE_RD_USER, 12'd0, 12'd0, 15'd0, 4'd0, 16'sd0, 12'd0, 0, 16'sd0, 16'sd0, 1'b0},
		'{MODE_RD_USER, 12'd5, 12'd0, 15'd0, 4'd9, 16'sd0, 12'd0, 0, 16'sd0, 16'sd0, 1'b0},
		'{MODE_WR_USER, 12'd1, 12'd0, 15'd0, 4'd3, 16'sh8000, 12'd0, 1, 16'sd0, 16'sd0, 1'b0},
		'{MODE_TRAIN, 12'd1, 12'd4095, 15'h7fff, 4'd0, 16'sd0, 12'd0, 0, 16'sd0, 16'sd0, 1'b0}
	};

	// Phase settings: latent_size, neighbor_count, learn_rate, reg_lambda, social_lambda
	int unsigned phase_cfg [N_PHASES][5] = '{
		'{10, 5, 655, 655, 655},
		'{16, 8, 6554, 1311, 3277},
		'{1, 0, 65535, 65535, 65535},
		'{0, 15, 3000, 3000, 3000},
		'{31, 8, 0, 0, 0},
		'{7, 3, 20000, 100, 40000}
	};

	function automatic longint round_sh(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [FACT_W-1:0] clip16(longint v);
		if (v > 32767) begin
			clip_hit = 1;
			return 16'sh7fff;
		end
		if (v < -32768) begin
			clip_hit = 1;
			return 16'sh8000;
		end
		return v[FACT_W-1:0];
	endfunction

	// Work out the beat that one accepted item produces, updating the shadow state
	function automatic sgd_res_t sgd_predict(sgd_item_t it);
		sgd_res_t r;
		longint dims, nbs, acc, err, uo, io, g, w, s;
		int ub, ib;
		r.rv = '0;
		r.pe = '0;
		clip_hit = 0;
		dims = (dim_reg > LATENT_MAX) ? LATENT_MAX : dim_reg;
		nbs = (nbr_reg > TOPK_MAX) ? TOPK_MAX : nbr_reg;
		ub = int'(it.uid) * LATENT_MAX;
		ib = int'(it.iid) * LATENT_MAX;
		case (it.mode)
			MODE_TRAIN: begin
				acc = 0;
				for (int k = 0; k < dims; k++)
					acc += longint'(user_tab[ub+k]) * longint'(item_tab[ib+k]);
				r.pe = clip16(round_sh(longint'(it.rating) * 4096 - acc, 12));
				err = r.pe;
				for (int k = 0; k < dims; k++) begin
					uo = user_tab[ub+k];
					io = item_tab[ib+k];
					g = -(err * io) * 16 + lambda_reg * uo;
					user_tab[ub+k] = clip16(uo - round_sh(lrate_reg * g, 32));
					g = -(err * longint'(user_tab[ub+k])) * 16 + lambda_reg * io;
					item_tab[ib+k] = clip16(io - round_sh(lrate_reg * g, 32));
				end
				if (social_on[it.uid]) begin
					w = lrate_reg * social_reg;
					for (int k = 0; k < dims; k++) begin
						s = 0;
						for (int j = 0; j < nbs; j++)
							s += longint'(user_tab[ub+k]) -
								longint'(user_tab[int'(nbr_tab[int'(it.uid)*TOPK_MAX+j])
								* LATENT_MAX + k]);
						user_tab[ub+k] = clip16(longint'(user_tab[ub+k]) - round_sh(w * s, 32));
					end
				end
			end
			MODE_WR_USER: user_tab[ub+it.el] = it.fv;
			MODE_WR_ITEM: item_tab[ib+it.el] = it.fv;
			MODE_WR_NBR: begin
				if (it.el < TOPK_MAX) begin
					nbr_tab[int'(it.uid)*TOPK_MAX+it.el] = it.nid;
					social_on[it.uid] = 1;
				end
			end
			MODE_RD_USER: r.rv = user_tab[ub+it.el];
			MODE_RD_ITEM: r.rv = item_tab[ib+it.el];
			default: ;
		endcase
		r.sat = clip_hit;
		return r;
	endfunction

	// Offer one beat, hold it until taken, then queue what it must produce.
	// use_typed selects a hand-written result over the computed one.
	task automatic send_item(sgd_item_t it, bit use_typed, sgd_res_t typed);
		sgd_res_t r;
		if (!calm && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		mode <= it.mode;
		user_id <= it.uid;
		item_id <= it.iid;
		rating <= it.rating;
		element_index <= it.el;
		factor_value <= it.fv;
		neighbor_id <= it.nid;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		r = sgd_predict(it);
		pending_res.insert(pending_res.size(), use_typed ? typed : r);
	endtask

	// Hold cfg_valid high across a run of writes; the caller drops it
	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFGD_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_LATENT:  dim_reg = val & 32'h1f;
			CFG_NBR_CNT: nbr_reg = val & 32'hf;
			CFG_LRATE:   lrate_reg = val & 32'hffff;
			CFG_REG:     lambda_reg = val & 32'hffff;
			CFG_SOCIAL:  social_reg = val & 32'hffff;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_res.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic signed [FACT_W-1:0] rand_factor();
		if ($urandom_range(99) < 80)
			return 16'($signed($urandom_range(16384)) - 8192);
		return 16'($urandom);
	endfunction

	// Mostly well-formed traffic on the loaded ids; a slice of writes to
	// arbitrary ids, spare modes and out-of-range neighbor slots as noise
	function automatic sgd_item_t rand_item();
		sgd_item_t it;
		int unsigned pick;
		it.mode = MODE_TRAIN;
		it.uid = ID_W'(user_pool[$urandom_range(8)]);
		it.iid = ID_W'(item_pool[$urandom_range(8)]);
		it.rating = 15'($urandom);
		it.el = 4'($urandom);
		it.fv = 16'($urandom);
		it.nid = 12'($urandom);
		pick = $urandom_range(99);
		if (pick < 45)
			it.mode = MODE_TRAIN;
		else if (pick < 55) begin
			it.mode = MODE_WR_USER;
			it.fv = rand_factor();
			if ($urandom_range(2) == 0) it.uid = 12'($urandom);
		end else if (pick < 65) begin
			it.mode = MODE_WR_ITEM;
			it.fv = rand_factor();
			if ($urandom_range(2) == 0) it.iid = 12'($urandom);
		end else if (pick < 73) begin
			// real slots only on users that already hold full lists
			it.mode = MODE_WR_NBR;
			it.nid = ID_W'(user_pool[$urandom_range(8)]);
			if ($urandom_range(3) == 0) begin
				it.uid = 12'($urandom);
				it.el = 4'($urandom_range(TOPK_MAX, 15));
			end else begin
				it.uid = ID_W'(user_pool[$urandom_range(4)]);
				it.el = 4'($urandom_range(TOPK_MAX - 1));
			end
		end else if (pick < 83)
			it.mode = MODE_RD_USER;
		else if (pick < 93)
			it.mode = MODE_RD_ITEM;
		else
			it.mode = ($urandom_range(1) == 0) ? MODE_SPARE_A : MODE_SPARE_B;
		return it;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, a calm stretch, and a long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_ready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_ready <= calm || ($urandom_range(99) >= 23);
		end
	end

	// Compare every result beat against the oldest expectation
	always @(posedge clk) begin
		sgd_res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_res.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: rv=%0d pe=%0d sat=%0b",
						read_value, prediction_error, saturated);
			end else begin
				e = pending_res.pop_front();
				if (e.rv !== read_value || e.pe !== prediction_error || e.sat !== saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected rv=%0d pe=%0d sat=%0b got rv=%0d pe=%0d sat=%0b",
							e.rv, e.pe, e.sat, read_value, prediction_error, saturated);
				end
			end
		end
	end

	initial begin
		#30ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		sgd_item_t it;
		sgd_res_t typed;
		int guard;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		mode = '0;
		user_id = '0;
		item_id = '0;
		rating = '0;
		element_index = '0;
		factor_value = '0;
		neighbor_id = '0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		calm = 0;
		hold_cycles = 0;
		dim_reg = 10;
		nbr_reg = 5;
		lrate_reg = 655;
		lambda_reg = 655;
		social_reg = 655;
		for (int i = 0; i < NUM_USERS; i++) social_on[i] = 0;
		typed = '{rv: 0, pe: 0, sat: 0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Load every factor of the id pool, and full neighbor lists for the
		// first five users, so nothing unwritten is ever read
		it.rating = 15'($urandom);
		it.nid = '0;
		for (int p = 0; p < 9; p++)
			for (int k = 0; k < LATENT_MAX; k++) begin
				it.mode = MODE_WR_USER;
				it.uid = ID_W'(user_pool[p]);
				it.iid = 12'($urandom);
				it.el = EL_W'(k);
				it.fv = rand_factor();
				send_item(it, 0, typed);
				it.mode = MODE_WR_ITEM;
				it.iid = ID_W'(item_pool[p]);
				it.fv = rand_factor();
				send_item(it, 0, typed);
			end
		for (int p = 0; p < 5; p++)
			for (int j = 0; j < TOPK_MAX; j++) begin
				it.mode = MODE_WR_NBR;
				it.uid = ID_W'(user_pool[p]);
				it.el = EL_W'(j);
				it.nid = ID_W'(user_pool[$urandom_range(8)]);
				send_item(it, 0, typed);
			end

		// Directed rows at reset settings
		foreach (dir_rows[i]) begin
			it = '{dir_rows[i].mode, dir_rows[i].uid, dir_rows[i].iid, dir_rows[i].rating,
				dir_rows[i].el, dir_rows[i].fv, dir_rows[i].nid};
			typed = '{rv: dir_rows[i].rv, pe: dir_rows[i].pe, sat: dir_rows[i].sat};
			send_item(it, dir_rows[i].chk, typed);
		end

		// Random phases, each under its own register settings
		for (int ph = 0; ph < N_PHASES; ph++) begin
			in_valid <= 1'b0;
			wait_drained();
			write_reg(CFG_LATENT, phase_cfg[ph][0]);
			write_reg(CFG_NBR_CNT, phase_cfg[ph][1]);
			write_reg(CFG_LRATE, phase_cfg[ph][2]);
			write_reg(CFG_REG, phase_cfg[ph][3]);
			write_reg(CFG_SOCIAL, phase_cfg[ph][4]);
			cfg_valid <= 1'b0;
			calm = (ph == N_PHASES - 1);
			// stall the receiver long enough to back up the input
			if (ph == 1) hold_cycles = 3000;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(rand_item(), 0, typed);
		end
		in_valid <= 1'b0;
		calm = 0;

		guard = 0;
		while (pending_res.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (600) @(posedge clk);
		if (mismatches == 0 && pending_res.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
src/sgdu_pkg.sv
src/sgdu_ram.sv
src/sgdu_ctrl.sv
src/sgdu_dp.sv
src/social_mf_sgd_update_unit.sv
sim/tb.sv
